// File: rtl/weighted_window_average_core_defines.svh
// ----------------------------------------------------------------------------
// Weighted window average core: assertion macros
// Shared property shorthands for the core's RTL assertions.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_WINDOW_AVERAGE_CORE_DEFINES_SVH
`define WEIGHTED_WINDOW_AVERAGE_CORE_DEFINES_SVH

// same-cycle implication
`define WWA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WWA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/wwa_pkg.sv
// ----------------------------------------------------------------------------
// Weighted window average package
// Sizes, shared types and helpers of the weighted window average core.
// ----------------------------------------------------------------------------
package wwa_pkg;

   localparam int MAX_HALF_WINDOW = 8;
   localparam int WIN_DEPTH       = 2 * MAX_HALF_WINDOW;
   localparam int AGE_W           = $clog2(WIN_DEPTH);
   localparam int CNT_W           = $clog2(WIN_DEPTH + 1);
   localparam int HW_W            = $clog2(MAX_HALF_WINDOW + 1);
   localparam int CSR_W           = 4;
   localparam int RANGE_W         = 16;
   localparam int WEIGHT_W        = 32;
   localparam int ANGLE_W         = 9;
   localparam int PROD_W          = RANGE_W + WEIGHT_W;
   localparam int NUM_W           = PROD_W + AGE_W;
   localparam int DEN_W           = WEIGHT_W + AGE_W;
   localparam int QCNT_W          = $clog2(RANGE_W);

   localparam logic [CSR_W-1:0] HALF_WINDOW_RESET = CSR_W'(2);

   typedef struct packed {
      logic [RANGE_W-1:0]         sample_range;
      logic [WEIGHT_W-1:0]        sample_weight;
      logic signed [ANGLE_W-1:0]  bin_angle;
   } sample_type;

   typedef struct packed {
      logic load;
      logic rotate;
   } win_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // zero acts as one, values above the maximum saturate
   function automatic logic [HW_W-1:0] clamp_half(input logic [CSR_W-1:0] hw);
      logic [HW_W-1:0] res;
      if (hw == '0) begin
         res = HW_W'(1);
      end else if (int'(hw) > MAX_HALF_WINDOW) begin
         res = HW_W'(MAX_HALF_WINDOW);
      end else begin
         res = HW_W'(hw);
      end
      return res;
   endfunction

endpackage

// File: rtl/wwa_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// One sample slot of the window ring; takes its neighbor's sample on shift.
// ----------------------------------------------------------------------------
module wwa_cell (
   input  logic                clock,
   input  logic                shift,
   input  wwa_pkg::sample_type prev_sample,
   output wwa_pkg::sample_type sample
);
   import wwa_pkg::*;

   sample_type data_ff;
   sample_type data_in;

   always_comb begin
      data_in = shift ? prev_sample : data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign sample = data_ff;

endmodule

// File: rtl/wwa_window.sv
// ----------------------------------------------------------------------------
// Window ring
// Row of cells, newest sample at cell 0. Load pushes a new sample in; rotate
// circulates the ring so that every age passes the tap once per full turn.
// ----------------------------------------------------------------------------
module wwa_window (
   input  logic                  clock,
   input  wwa_pkg::win_ctrl_type ctrl,
   input  wwa_pkg::sample_type   sample_in,
   output wwa_pkg::sample_type   tap
);
   import wwa_pkg::*;

   sample_type cell_q [WIN_DEPTH];
   sample_type head;
   logic       shift;

   assign shift = ctrl.load | ctrl.rotate;
   assign head  = ctrl.load ? sample_in : cell_q[WIN_DEPTH-1];

   for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         wwa_cell u_cell (
            .clock       (clock),
            .shift       (shift),
            .prev_sample (head),
            .sample      (cell_q[k])
         );
      end else begin : g_body
         wwa_cell u_cell (
            .clock       (clock),
            .shift       (shift),
            .prev_sample (cell_q[k-1]),
            .sample      (cell_q[k])
         );
      end
   end

   assign tap = cell_q[WIN_DEPTH-1];

endmodule

// File: rtl/wwa_mac.sv
// ----------------------------------------------------------------------------
// Window accumulator
// Registered weight-by-range product at the ring tap, summed with the weight.
// ----------------------------------------------------------------------------
module wwa_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic                              take,
   input  wwa_pkg::sample_type               tap,
   output logic [wwa_pkg::NUM_W-1:0]         num,
   output logic [wwa_pkg::DEN_W-1:0]         den
);
   import wwa_pkg::*;

   logic [PROD_W-1:0]   prod_ff;
   logic [WEIGHT_W-1:0] wgt_ff;
   logic                take_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [NUM_W-1:0]    num_in;
   logic [DEN_W-1:0]    den_ff;
   logic [DEN_W-1:0]    den_in;

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      if (clear) begin
         num_in = '0;
         den_in = '0;
      end else if (take_ff) begin
         num_in = num_ff + NUM_W'(prod_ff);
         den_in = den_ff + DEN_W'(wgt_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= tap.sample_weight * tap.sample_range;
      wgt_ff  <= tap.sample_weight;
      num_ff  <= num_in;
      den_ff  <= den_in;
      if (reset) begin
         take_ff <= 1'b0;
      end else begin
         take_ff <= take;
      end
   end

   assign num = num_ff;
   assign den = den_ff;

endmodule

// File: rtl/wwa_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle, most significant first; the quotient is known
// to fit the range width. A zero divisor is flagged.
// ----------------------------------------------------------------------------
module wwa_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wwa_pkg::NUM_W-1:0]   num,
   input  logic [wwa_pkg::DEN_W-1:0]   den,
   output wwa_pkg::div_stat_type       stat,
   output logic [wwa_pkg::RANGE_W-1:0] quotient,
   output logic                        den_zero
);
   import wwa_pkg::*;

   localparam logic [QCNT_W-1:0] CNT_LAST = QCNT_W'(RANGE_W - 1);

   logic [NUM_W-1:0]   rem_ff;
   logic [NUM_W-1:0]   rem_in;
   logic [NUM_W-1:0]   dsr_ff;
   logic [NUM_W-1:0]   dsr_in;
   logic [RANGE_W-1:0] quo_ff;
   logic [RANGE_W-1:0] quo_in;
   logic [QCNT_W-1:0]  cnt_ff;
   logic [QCNT_W-1:0]  cnt_in;
   logic               busy_ff;
   logic               busy_in;
   logic               done_ff;
   logic               done_in;
   logic               zero_ff;
   logic               zero_in;
   logic               fits;

   assign fits = (rem_ff >= dsr_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dsr_in  = NUM_W'(den) << (RANGE_W - 1);
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         zero_in = (den == '0);
      end else if (busy_ff) begin
         rem_in = fits ? (rem_ff - dsr_ff) : rem_ff;
         dsr_in = dsr_ff >> 1;
         quo_in = {quo_ff[RANGE_W-2:0], fits};
         cnt_in = cnt_ff + QCNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign den_zero  = zero_ff;

endmodule

// File: rtl/weighted_window_average_core.sv
// ----------------------------------------------------------------------------
// Weighted window average core
// Weighted moving average of range samples over a clipped window of reach H.
// ----------------------------------------------------------------------------
// Samples enter on the req_ channel, results leave on the rsp_ channel, both
// valid/ready. H is written on the csr_ channel (always ready); the user must
// write it only while idle, which the core itself does not enforce. Each
// accepted transaction is pushed into a ring of cells. Each result then takes
// one full turn of the ring (one cell per cycle through a single
// multiply-accumulate), a flush state to drain the accumulator, a launch state,
// a restoring divide at one quotient bit per cycle, and a done state that parks
// it in the output register. When rsp_valid rises the core is back in idle,
// ready for the next transaction, unless a last transaction still has results
// pending. A transaction that yields no result leaves the core idle.
// Results lag H-1 transactions behind the input; the transaction marked last
// produces all pending results (up to H) back to back.
// The core takes one transaction at a time; it accepts the next one as soon
// as the result is parked in the output register, even if rsp_ready is low.
// A stalled receiver holds the output register and, once the next result is
// finished, the core waits for it.
// Reset sets H to 2 and starts a new stream; window cells are not cleared.
// ----------------------------------------------------------------------------
`include "weighted_window_average_core_defines.svh"

module weighted_window_average_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [wwa_pkg::RANGE_W-1:0]        req_sample_range,
   input  logic [wwa_pkg::WEIGHT_W-1:0]       req_sample_weight,
   input  logic signed [wwa_pkg::ANGLE_W-1:0] req_bin_angle,
   input  logic                               req_last_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [wwa_pkg::RANGE_W-1:0]        rsp_filtered_range,
   output logic signed [wwa_pkg::ANGLE_W-1:0] rsp_angle_out,
   output logic                               rsp_zero_weight,
   output logic                               rsp_last_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wwa_pkg::CSR_W-1:0]          csr_half_window
);
   import wwa_pkg::*;

   localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(WIN_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIN_DEPTH);

   state_type                  state_ff;
   state_type                  state_in;
   logic [AGE_W-1:0]           step_ff;
   logic [AGE_W-1:0]           step_in;
   logic [AGE_W-1:0]           c_ff;
   logic [AGE_W-1:0]           c_in;
   logic [CNT_W-1:0]           n_ff;
   logic [CNT_W-1:0]           n_in;
   logic [HW_W-1:0]            h_ff;
   logic [HW_W-1:0]            h_in;
   logic                       strm_last_ff;
   logic                       strm_last_in;
   logic [CNT_W-1:0]           seen_ff;
   logic [CNT_W-1:0]           seen_in;
   logic [CSR_W-1:0]           half_window_ff;
   logic [CSR_W-1:0]           half_window_in;
   logic signed [ANGLE_W-1:0]  angle_ff;
   logic signed [ANGLE_W-1:0]  angle_in;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [RANGE_W-1:0]         range_out_ff;
   logic signed [ANGLE_W-1:0]  angle_out_ff;
   logic                       zero_out_ff;
   logic                       last_out_ff;

   sample_type                 sample_in;
   sample_type                 tap;
   win_ctrl_type               win_ctrl;
   div_stat_type               div_stat;
   logic [NUM_W-1:0]           num;
   logic [DEN_W-1:0]           den;
   logic [RANGE_W-1:0]         quotient;
   logic                       den_zero;
   logic                       mac_clear;
   logic                       take;
   logic                       div_start;
   logic                       out_load;

   logic [HW_W-1:0]            h_new;
   logic [CNT_W-1:0]           n_new;
   logic [CNT_W-1:0]           hm1_new;
   logic [CNT_W-1:0]           c_new;
   logic                       fill_ok;
   logic [AGE_W-1:0]           age;
   logic [CNT_W-1:0]           age_ext;
   logic [CNT_W-1:0]           c_ext;
   logic [CNT_W-1:0]           h_ext;
   logic [CNT_W-1:0]           hi_raw;
   logic [CNT_W-1:0]           lo_raw;
   logic [CNT_W-1:0]           nm1;
   logic [CNT_W-1:0]           lo;
   logic [CNT_W-1:0]           hi;

   assign sample_in.sample_range  = req_sample_range;
   assign sample_in.sample_weight = req_sample_weight;
   assign sample_in.bin_angle     = req_bin_angle;

   // stream bookkeeping for a new transaction
   assign h_new   = clamp_half(half_window_ff);
   assign n_new   = (seen_ff == CNT_FULL) ? seen_ff : seen_ff + CNT_W'(1);
   assign hm1_new = CNT_W'(h_new) - CNT_W'(1);
   assign fill_ok = (hm1_new < n_new);
   assign c_new   = fill_ok ? hm1_new : n_new - CNT_W'(1);

   // window bounds of the current center, clipped to the stream
   assign age     = AGE_LAST - step_ff;
   assign age_ext = CNT_W'(age);
   assign c_ext   = CNT_W'(c_ff);
   assign h_ext   = CNT_W'(h_ff);
   assign hi_raw  = c_ext + h_ext;
   assign nm1     = n_ff - CNT_W'(1);
   assign hi      = (hi_raw > nm1) ? nm1 : hi_raw;
   assign lo_raw  = c_ext + CNT_W'(1);
   assign lo      = (lo_raw >= h_ext) ? lo_raw - h_ext : '0;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      c_in         = c_ff;
      n_in         = n_ff;
      h_in         = h_ff;
      strm_last_in = strm_last_ff;
      seen_in      = seen_ff;
      angle_in     = angle_ff;
      req_ready    = 1'b0;
      win_ctrl     = '0;
      mac_clear    = 1'b0;
      take         = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               win_ctrl.load = 1'b1;
               n_in          = n_new;
               h_in          = h_new;
               strm_last_in  = req_last_in;
               seen_in       = req_last_in ? '0 : n_new;
               c_in          = c_new[AGE_W-1:0];
               step_in       = '0;
               if (req_last_in || fill_ok) begin
                  mac_clear = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            win_ctrl.rotate = 1'b1;
            take            = (age_ext >= lo) && (age_ext <= hi);
            if (age == c_ff) begin
               angle_in = tap.bin_angle;
            end
            if (step_ff == AGE_LAST) begin
               step_in  = '0;
               state_in = ST_FLUSH;
            end else begin
               step_in = step_ff + AGE_W'(1);
            end
         end
         ST_FLUSH: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               if (strm_last_ff && (c_ff != '0)) begin
                  c_in      = c_ff - AGE_W'(1);
                  mac_clear = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      half_window_in = csr_valid ? csr_half_window : half_window_ff;
      rsp_valid_in   = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      c_ff         <= c_in;
      n_ff         <= n_in;
      h_ff         <= h_in;
      strm_last_ff <= strm_last_in;
      angle_ff     <= angle_in;
      if (out_load) begin
         range_out_ff <= den_zero ? '0 : quotient;
         zero_out_ff  <= den_zero;
         angle_out_ff <= angle_ff;
         last_out_ff  <= strm_last_ff && (c_ff == '0);
      end
      if (reset) begin
         state_ff       <= ST_IDLE;
         seen_ff        <= '0;
         half_window_ff <= HALF_WINDOW_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seen_ff        <= seen_in;
         half_window_ff <= half_window_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   wwa_window u_window (
      .clock     (clock),
      .ctrl      (win_ctrl),
      .sample_in (sample_in),
      .tap       (tap)
   );

   wwa_mac u_mac (
      .clock (clock),
      .reset (reset),
      .clear (mac_clear),
      .take  (take),
      .tap   (tap),
      .num   (num),
      .den   (den)
   );

   wwa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num),
      .den      (den),
      .stat     (div_stat),
      .quotient (quotient),
      .den_zero (den_zero)
   );

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_range = range_out_ff;
   assign rsp_angle_out      = angle_out_ff;
   assign rsp_zero_weight    = zero_out_ff;
   assign rsp_last_out       = last_out_ff;

   `WWA_ASSERT_IMPL(a_zero_weight_range, clock, reset, rsp_valid && rsp_zero_weight, rsp_filtered_range == '0, "zero weight result with nonzero range")
   `WWA_ASSERT_IMPL(a_ring_restored, clock, reset, state_ff == ST_FLUSH, step_ff == '0, "ring turn incomplete")
   `WWA_ASSERT_IMPL(a_center_in_window, clock, reset, state_ff == ST_SCAN, (c_ext < n_ff) && (lo <= c_ext) && (c_ext <= hi), "center outside its window")
   `WWA_ASSERT_IMPL(a_div_done_state, clock, reset, div_stat.done, state_ff == ST_DIVIDE, "divide finished outside divide state")
   `WWA_ASSERT_NEXT(a_div_launch, clock, reset, state_ff == ST_LAUNCH, div_stat.busy, "divider not started")

endmodule

// File: tb/tb_weighted_window_average_core.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// Weighted window average core testbench
// Sends streams of range samples with random idles on both channels, computes
// the clipped weighted window average of every transaction on the side and
// compares each result field by field, in order, across half-window settings.
// ----------------------------------------------------------------------------
module tb_weighted_window_average_core;
   import wwa_pkg::*;

   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 400;
   localparam int NUM_PHASES    = 9;
   localparam int PHASE_ITEMS   = RANDOM_ITEMS / NUM_PHASES;
   localparam int MAX_REPORTS   = 10;

   localparam logic [CSR_W-1:0] PHASE_HALF [7] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd9};

   typedef struct packed {
      logic [RANGE_W-1:0]        filtered_range;
      logic signed [ANGLE_W-1:0] angle_out;
      logic                      zero_weight;
      logic                      last_out;
   } average_result_type;

   logic                       clock;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_ready;
   logic [RANGE_W-1:0]         req_sample_range  = '0;
   logic [WEIGHT_W-1:0]        req_sample_weight = '0;
   logic signed [ANGLE_W-1:0]  req_bin_angle     = '0;
   logic                       req_last_in       = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready         = 1'b0;
   logic [RANGE_W-1:0]         rsp_filtered_range;
   logic signed [ANGLE_W-1:0]  rsp_angle_out;
   logic                       rsp_zero_weight;
   logic                       rsp_last_out;
   logic                       csr_valid         = 1'b0;
   logic                       csr_ready;
   logic [CSR_W-1:0]           csr_half_window   = '0;

   // shadow of the core's window, newest sample at index 0
   logic [CSR_W-1:0]           half_window_reg = HALF_WINDOW_RESET;
   logic [RANGE_W-1:0]         range_hist  [WIN_DEPTH];
   logic [WEIGHT_W-1:0]        weight_hist [WIN_DEPTH];
   logic signed [ANGLE_W-1:0]  angle_hist  [WIN_DEPTH];
   int                         stream_len = 0;
   average_result_type         expected_averages [$];

   int unsigned                fail_count  = 0;
   int unsigned                cycle_count = 0;
   int unsigned                stall_left  = 0;
   bit                         sender_idle   = 1'b1;
   bit                         receiver_idle = 1'b1;

   weighted_window_average_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_range   (req_sample_range),
      .req_sample_weight  (req_sample_weight),
      .req_bin_angle      (req_bin_angle),
      .req_last_in        (req_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_range (rsp_filtered_range),
      .rsp_angle_out      (rsp_angle_out),
      .rsp_zero_weight    (rsp_zero_weight),
      .rsp_last_out       (rsp_last_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_half_window    (csr_half_window)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // average of the window centered at age center, clipped to the stream
   function automatic average_result_type window_average(input int center, input int count,
                                                         input int reach, input bit last);
      average_result_type res;
      int                 lo;
      int                 hi;
      logic [63:0]        num;
      logic [63:0]        den;
      lo  = (center + 1 >= reach) ? center + 1 - reach : 0;
      hi  = center + reach;
      num = '0;
      den = '0;
      if (hi > count - 1) hi = count - 1;
      if (hi > WIN_DEPTH - 1) hi = WIN_DEPTH - 1;
      for (int a = lo; a <= hi; a++) begin
         num += 64'(weight_hist[a]) * 64'(range_hist[a]);
         den += 64'(weight_hist[a]);
      end
      if (den == '0) begin
         res.filtered_range = '0;
         res.zero_weight    = 1'b1;
      end else begin
         res.filtered_range = RANGE_W'(num / den);
         res.zero_weight    = 1'b0;
      end
      res.angle_out = angle_hist[center];
      res.last_out  = last;
      return res;
   endfunction

   function automatic void queue_average(input average_result_type res);
      expected_averages = {expected_averages, res};
   endfunction

   function automatic void predict_sample_averages(input logic [RANGE_W-1:0] rng,
                                                   input logic [WEIGHT_W-1:0] wgt,
                                                   input logic signed [ANGLE_W-1:0] angle,
                                                   input logic last);
      int reach;
      int center;
      reach = int'(half_window_reg);
      if (reach == 0) reach = 1;
      else if (reach > MAX_HALF_WINDOW) reach = MAX_HALF_WINDOW;
      for (int a = WIN_DEPTH - 1; a > 0; a--) begin
         range_hist[a]  = range_hist[a-1];
         weight_hist[a] = weight_hist[a-1];
         angle_hist[a]  = angle_hist[a-1];
      end
      range_hist[0]  = rng;
      weight_hist[0] = wgt;
      angle_hist[0]  = angle;
      if (stream_len < WIN_DEPTH) stream_len++;
      if (!last) begin
         if (reach - 1 < stream_len) begin
            queue_average(window_average(reach - 1, stream_len, reach, 1'b0));
         end
      end else begin
         center = (reach - 1 < stream_len) ? reach - 1 : stream_len - 1;
         for (int c = center; c >= 0; c--) begin
            queue_average(window_average(c, stream_len, reach, c == 0));
         end
         stream_len = 0;
      end
   endfunction

   task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic [WEIGHT_W-1:0] wgt,
                              input logic signed [ANGLE_W-1:0] angle, input logic last);
      int unsigned gap;
      gap = 0;
      if (sender_idle) begin
         while ($urandom_range(0, 99) < 31) gap++;
         if ($urandom_range(0, 99) < 3) gap += $urandom_range(20, 60);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_range  <= rng;
      req_sample_weight <= wgt;
      req_bin_angle     <= angle;
      req_last_in       <= last;
      do @(posedge clock); while (!req_ready);
      predict_sample_averages(rng, wgt, angle, last);
   endtask

   // hold the sender until every pending result is back and the core is quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_half_window(input logic [CSR_W-1:0] value);
      wait_idle();
      csr_valid       <= 1'b1;
      csr_half_window <= value;
      do @(posedge clock); while (!csr_ready);
      half_window_reg = value;
      csr_valid       <= 1'b0;
   endtask

   task automatic send_random_stream(input int unsigned len, input bit zero_weights,
                                     input bit close_stream);
      logic [RANGE_W-1:0]        rng;
      logic [WEIGHT_W-1:0]       wgt;
      logic signed [ANGLE_W-1:0] angle;
      int unsigned               sel;
      for (int unsigned k = 0; k < len; k++) begin
         sel = $urandom_range(0, 19);
         rng = (sel == 0) ? '0 : (sel == 1) ? '1 : RANGE_W'($urandom);
         sel = $urandom_range(0, 19);
         if (zero_weights || sel < 2) wgt = '0;
         else if (sel == 2) wgt = '1;
         else if (sel == 3) wgt = WEIGHT_W'($urandom_range(1, 255));
         else wgt = WEIGHT_W'($urandom);
         angle = ANGLE_W'(int'($urandom_range(0, 360)) - 180);
         send_sample(rng, wgt, angle, close_stream && (k == len - 1));
      end
   endtask

   // half window of 2 straight out of reset, extreme field values
   task automatic test_reset_extremes();
      send_sample('0, '1, -9'sd180, 1'b0);
      send_sample('1, '1, 9'sd180, 1'b0);
      send_sample('1, 32'd1, 9'sd0, 1'b0);
      send_sample('0, '0, -9'sd1, 1'b0);
      send_sample(16'h8000, 32'h8000_0000, 9'sd170, 1'b1);
      wait_idle();
   endtask

   task automatic test_zero_weight();
      write_half_window(4'd3);
      send_sample(16'h1234, '0, 9'sd10, 1'b0);
      send_sample('1, '0, 9'sd20, 1'b0);
      send_sample(16'h00ff, '0, 9'sd30, 1'b1);
      wait_idle();
   endtask

   task automatic test_short_stream();
      write_half_window(4'd8);
      send_sample(16'h0a00, 32'h0100_0000, -9'sd90, 1'b0);
      send_sample(16'h1400, 32'h0300_0000, 9'sd90, 1'b1);
      send_sample(16'h0001, 32'hffff_0000, 9'sd45, 1'b1);
      wait_idle();
   endtask

   task automatic test_half_window_clamp();
      write_half_window(4'd0);
      send_sample(16'h0100, 32'h0000_0010, 9'sd1, 1'b0);
      send_sample(16'h0200, 32'h0000_0020, 9'sd2, 1'b0);
      send_sample(16'h0300, 32'h0000_0030, 9'sd3, 1'b1);
      write_half_window(4'd15);
      send_sample(16'hff00, 32'h7fff_ffff, -9'sd4, 1'b0);
      send_sample(16'h00ff, 32'h8000_0001, -9'sd5, 1'b0);
      send_sample(16'h7777, 32'h0000_0001, -9'sd6, 1'b1);
      wait_idle();
   endtask

   task automatic test_mid_stream_change();
      write_half_window(4'd3);
      send_sample(16'h0400, 32'h1000_0000, 9'sd11, 1'b0);
      send_sample(16'h0800, 32'h2000_0000, 9'sd12, 1'b0);
      send_sample(16'h0c00, 32'h3000_0000, 9'sd13, 1'b0);
      send_sample(16'h1000, 32'h4000_0000, 9'sd14, 1'b0);
      write_half_window(4'd6);
      send_sample(16'h1400, 32'h5000_0000, 9'sd15, 1'b0);
      send_sample(16'h1800, 32'h6000_0000, 9'sd16, 1'b0);
      send_sample(16'h1c00, 32'h7000_0000, 9'sd17, 1'b1);
      wait_idle();
   endtask

   // odd phases leave a stream open so the next setting lands mid-stream
   task automatic test_random_streams();
      int unsigned      phase_sent;
      int unsigned      len;
      logic [CSR_W-1:0] value;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         value = (phase < 7) ? PHASE_HALF[phase] : CSR_W'($urandom_range(0, 15));
         write_half_window(value);
         sender_idle   = (phase != 3);
         receiver_idle = (phase != 3);
         phase_sent    = 0;
         while (phase_sent < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 36) : $urandom_range(1, 16);
            if (len > PHASE_ITEMS - phase_sent) len = PHASE_ITEMS - phase_sent;
            send_random_stream(len, $urandom_range(0, 11) == 0, 1'b1);
            phase_sent += len;
         end
         if (phase % 2 == 1) send_random_stream($urandom_range(1, 6), 1'b0, 1'b0);
      end
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!receiver_idle) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 199) == 0) begin
         stall_left <= $urandom_range(10, 60);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 31);
      end
   end

   always @(posedge clock) begin : check_averages
      average_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_averages.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("unexpected transaction: range=%0d angle=%0d zero=%0b last=%0b",
                        rsp_filtered_range, rsp_angle_out, rsp_zero_weight, rsp_last_out);
            end
         end else begin
            want = expected_averages.pop_front();
            if (rsp_filtered_range !== want.filtered_range || rsp_angle_out !== want.angle_out ||
                rsp_zero_weight !== want.zero_weight || rsp_last_out !== want.last_out) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("mismatch: expected range=%0d angle=%0d zero=%0b last=%0b",
                           want.filtered_range, want.angle_out, want.zero_weight,
                           want.last_out);
                  $display("          actual   range=%0d angle=%0d zero=%0b last=%0b",
                           rsp_filtered_range, rsp_angle_out, rsp_zero_weight, rsp_last_out);
               end
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_extremes();
      test_zero_weight();
      test_short_stream();
      test_half_window_clamp();
      test_mid_stream_change();
      test_random_streams();
      wait_idle();
      if (fail_count == 0 && expected_averages.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: weighted_window_average_core.f
+incdir+rtl
rtl/wwa_pkg.sv
rtl/wwa_cell.sv
rtl/wwa_window.sv
rtl/wwa_mac.sv
rtl/wwa_divider.sv
rtl/weighted_window_average_core.sv
tb/tb_weighted_window_average_core.sv
